>>> rtl/bsh_pkg.sv
`default_nettype none
package bsh_pkg;

    localparam int WORD_COUNT = 8;
    localparam int WORD_W = 64;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam logic [7:0] ROUND_COUNT_RESET = 8'd32;
    localparam logic [63:0] MIX_MUL_A = 64'hd6e8feb86659fd93;
    localparam logic [63:0] MIX_MUL_B = 64'h9e3779b185ebca87;

    // op codes
    localparam logic [1:0] OP_ABSORB = 2'd0;
    localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // classified item passed from front to back
    typedef struct packed {
        logic       absorb;
        logic       finish;
        logic [7:0] data_byte;
    } bsh_item_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] amt);
        logic [6:0] rev;
        rev = 7'd64 - {1'b0, amt};
        if (amt == 6'd0) begin
            return x;
        end
        return (x << amt) | (x >> rev);
    endfunction

    // first half of the mixer, before the first multiply
    function automatic logic [63:0] mix_pre(input logic [63:0] x);
        logic [63:0] v;
        v = x;
        v = v ^ {v[46:0], v[63:47]};
        v = v ^ {v[12:0], v[63:13]};
        v = v ^ (v >> 32);
        return v;
    endfunction

    // middle of the mixer, between the two multiplies
    function automatic logic [63:0] mix_mid(input logic [63:0] x);
        logic [63:0] v;
        v = x;
        v = v ^ (v >> 29);
        v = v ^ {v[40:0], v[63:41]};
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bsh_front.sv
`default_nettype none
module bsh_front
    import bsh_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    output logic           item_valid,
    output bsh_item_t      item,
    input  wire logic      item_pop
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    bsh_item_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    bsh_item_t        in_item;

    // classify the incoming transfer; unused op codes are dropped
    always_comb begin
        in_item.absorb    = (s_tuser == OP_ABSORB) || (s_tuser == OP_ABSORB_FINISH);
        in_item.finish    = (s_tuser == OP_ABSORB_FINISH) || (s_tuser == OP_FINISH);
        in_item.data_byte = s_tdata;
    end

    assign s_tready   = (count_reg != CNT_W'(FIFO_DEPTH));
    assign push       = s_tvalid && s_tready && (s_tuser != OP_UNUSED);
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bsh_mixer.sv
`default_nettype none
module bsh_mixer
    import bsh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] word_in,
    output logic             done,
    output logic [63:0]      word_out
);

    // step 0 idle, 1..3 multiply by A, 4 middle, 5..7 multiply by B
    logic [2:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] b_const;
    logic [1:0]  phase;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;

    assign b_const = (step_reg >= 3'd5) ? MIX_MUL_B : MIX_MUL_A;
    assign phase   = (step_reg >= 3'd5) ? 2'(step_reg - 3'd5) : 2'(step_reg - 3'd1);

    // one 32x32 partial product per cycle, low 64 bits kept
    always_comb begin
        case (phase)
            2'd0: begin
                mul_x = a_reg[31:0];
                mul_y = b_const[31:0];
            end
            2'd1: begin
                mul_x = a_reg[31:0];
                mul_y = b_const[63:32];
            end
            default: begin
                mul_x = a_reg[63:32];
                mul_y = b_const[31:0];
            end
        endcase
        prod = {32'b0, mul_x} * {32'b0, mul_y};
    end

    always_comb begin
        step_next = step_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        case (step_reg)
            3'd0: begin
                if (start) begin
                    a_next    = mix_pre(word_in);
                    step_next = 3'd1;
                end
            end
            3'd4: begin
                a_next    = mix_mid(acc_reg);
                step_next = 3'd5;
            end
            default: begin
                if (phase == 2'd0) begin
                    acc_next = prod;
                end else begin
                    acc_next = acc_reg + {prod[31:0], 32'b0};
                end
                if (step_reg == 3'd7) begin
                    step_next = 3'd0;
                    done_next = 1'b1;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign word_out = acc_reg;

endmodule
`default_nettype wire

>>> rtl/bsh_back.sv
`default_nettype none
module bsh_back
    import bsh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  round_count,
    input  wire logic        item_valid,
    input  wire bsh_item_t   item,
    output logic             item_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic             m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MIX  = 4'b0010,
        ST_PERM = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] words_reg [WORD_COUNT];
    logic [63:0] words_next [WORD_COUNT];
    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  widx_reg, widx_next;
    logic [7:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] oword_reg, oword_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        mix_start;
    logic        mix_done;
    logic [63:0] mix_word;
    logic [63:0] perm_y [WORD_COUNT];
    logic [63:0] perm_z [WORD_COUNT];
    logic        out_load;

    bsh_mixer u_mixer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mix_start),
        .word_in  (words_reg[widx_reg]),
        .done     (mix_done),
        .word_out (mix_word)
    );

    // in-place xor with word i+3, then per-word rotation
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            perm_y[i] = words_reg[i] ^ words_reg[i + 3];
        end
        perm_y[5] = words_reg[5] ^ perm_y[0];
        perm_y[6] = words_reg[6] ^ perm_y[1];
        perm_y[7] = words_reg[7] ^ perm_y[2];
        for (int i = 0; i < WORD_COUNT; i++) begin
            perm_z[i] = rotl(perm_y[i], round_reg[5:0] + 6'(i * 7));
        end
    end

    assign item_pop  = (state_reg == ST_IDLE) && item_valid;
    assign mix_start = (state_reg == ST_MIX) && !busy_reg;
    assign out_load  = (state_reg == ST_OUT) && (!ovalid_reg || m_tready);

    always_comb begin
        state_next  = state_reg;
        words_next  = words_reg;
        pos_next    = pos_reg;
        widx_next   = widx_reg;
        round_next  = round_reg;
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;
        oidx_next   = oidx_reg;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    if (item.absorb) begin
                        for (int i = 0; i < WORD_COUNT; i++) begin
                            if (pos_reg == 3'(i)) begin
                                words_next[i][8*i +: 8] = words_reg[i][8*i +: 8] ^
                                                          item.data_byte;
                            end
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    if (item.finish) begin
                        round_next = '0;
                        widx_next  = '0;
                        oidx_next  = '0;
                        state_next = (round_count == 8'd0) ? ST_OUT : ST_MIX;
                    end
                end
            end
            ST_MIX: begin
                if (mix_start) begin
                    busy_next = 1'b1;
                end
                if (mix_done) begin
                    words_next[widx_reg] = mix_word;
                    busy_next = 1'b0;
                    widx_next = widx_reg + 1'b1;
                    if (widx_reg == 3'd7) begin
                        state_next = ST_PERM;
                    end
                end
            end
            ST_PERM: begin
                words_next[0] = perm_z[0] ^ {56'b0, round_reg};
                words_next[1] = perm_z[5];
                words_next[2] = perm_z[6];
                words_next[3] = perm_z[3];
                words_next[4] = perm_z[4];
                words_next[5] = perm_z[1];
                words_next[6] = perm_z[2];
                words_next[7] = perm_z[7];
                round_next = round_reg + 1'b1;
                state_next = (round_reg + 8'd1 == round_count) ? ST_OUT : ST_MIX;
            end
            ST_OUT: begin
                if (out_load) begin
                    ovalid_next = 1'b1;
                    oword_next  = words_reg[oidx_reg];
                    oidx_next   = oidx_reg + 1'b1;
                    if (oidx_reg == 3'd7) begin
                        for (int i = 0; i < WORD_COUNT; i++) begin
                            words_next[i] = '0;
                        end
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            widx_reg   <= '0;
            round_reg  <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < WORD_COUNT; i++) begin
                words_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            widx_reg   <= widx_next;
            round_reg  <= round_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            oidx_reg   <= oidx_next;
            words_reg  <= words_next;
        end
    end

    // output payload: word index is the one just loaded
    logic [2:0] oword_idx_reg;
    always_ff @(posedge aclk) begin
        oword_reg <= oword_next;
        if (out_load) begin
            oword_idx_reg <= oidx_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'b0, oword_idx_reg, oword_reg};
    assign m_tlast  = (oword_idx_reg == 3'd7);

endmodule
`default_nettype wire

>>> rtl/byte_stream_hash_512.sv
// Byte stream hash, 512-bit state in eight 64-bit words.
// Input channel s_*: one transfer per message byte. s_tuser carries the op
// (absorb, absorb then finish, finish only; the unused code is dropped),
// s_tdata the byte. Bytes are taken one per cycle while the queue has room, into a
// FIFO_DEPTH-entry queue (four by default), and absorbed one per cycle by the back end while it is idle.
// Output channel m_*: eight transfers per finish, word 0 first, m_tlast on
// the eighth. m_tdata carries the word and its index.
// Config channel cfg_*: round count, always ready; write only while idle.
// A finish is followed by round_count rounds, then eight words at one per cycle
// while the receiver is ready. Each round passes every word through the shared mixer
// (six 32x32 partial products), then one permutation step.
// Input stays accepted while the queue has room, so a stalled receiver
// backs up the queue; words wait in the output register until taken.
// Reset clears state, byte position and queue and sets 32 rounds.
`default_nettype none
module byte_stream_hash_512
    import bsh_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [63:0] digest_word, [66:64] word_index, zero pad
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // [7:0] round_count
);

    logic      [7:0] round_count_reg;
    logic            item_valid;
    logic            item_pop;
    bsh_item_t       item;

    // round count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_count_reg <= ROUND_COUNT_RESET;
        end else if (cfg_valid) begin
            round_count_reg <= cfg_data;
        end
    end

    bsh_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    bsh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .round_count (round_count_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    a_last_on_word7: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[66:64] == 3'd7)))
        else $error("tlast does not match word index");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71:67] == 5'd0))
        else $error("tdata padding not zero");
    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
        (m_tdata[66:64] == $past(m_tdata[66:64]) + 3'd1))
        else $error("digest words out of order");
`endif

endmodule
`default_nettype wire

>>> verif/tb_byte_stream_hash_512.sv
`timescale 1ns / 100ps
module tb_byte_stream_hash_512;
    import bsh_pkg::*;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // directed row: op, byte, and word 0 typed in where the others are zero
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  data;
        bit          typed;
        logic [63:0] word0;
    } stim_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 0;

    // model state
    logic [63:0] model_words [WORD_COUNT];
    logic [2:0]  model_pos;
    logic [7:0]  model_rounds;
    digest_beat_t digest_q [$];

    int  mismatches = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    bit  typed_now = 0;
    logic [63:0] typed_word0;

    byte_stream_hash_512 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] rot_l(input logic [63:0] x, input int amt);
        int a;
        a = amt % 64;
        if (a == 0) return x;
        return (x << a) | (x >> (64 - a));
    endfunction

    function automatic logic [63:0] scramble(input logic [63:0] x);
        logic [63:0] v;
        v = x;
        v = v ^ rot_l(v, 17);
        v = v ^ rot_l(v, 64 - 13);
        v = v ^ (v >> 32);
        v = v * MIX_MUL_A;
        v = v ^ (v >> 29);
        v = v ^ rot_l(v, 23);
        v = v * MIX_MUL_B;
        return v;
    endfunction

    // permute the model state and queue the eight digest words
    task automatic finish_digest();
        logic [63:0] t;
        digest_beat_t b;
        for (int r = 0; r < model_rounds; r++) begin
            for (int i = 0; i < WORD_COUNT; i++) model_words[i] = scramble(model_words[i]);
            for (int i = 0; i < WORD_COUNT; i++)
                model_words[i] = model_words[i] ^ model_words[(i + 3) % WORD_COUNT];
            for (int i = 0; i < WORD_COUNT; i++)
                model_words[i] = rot_l(model_words[i], (i * 7 + r) % 64);
            t = model_words[1]; model_words[1] = model_words[5]; model_words[5] = t;
            t = model_words[2]; model_words[2] = model_words[6]; model_words[6] = t;
            model_words[0] = model_words[0] ^ 64'(r);
        end
        for (int i = 0; i < WORD_COUNT; i++) begin
            b.word  = typed_now ? ((i == 0) ? typed_word0 : 64'd0) : model_words[i];
            b.index = 3'(i);
            b.last  = (i == WORD_COUNT - 1);
            digest_q.push_back(b);
            model_words[i] = 0;
        end
        model_pos = '0;
    endtask

    // input transfers update the model, output transfers are checked
    always @(posedge aclk) begin
        digest_beat_t e;
        if (aresetn && s_tvalid && s_tready && s_tuser != OP_UNUSED) begin
            if (s_tuser != OP_FINISH) begin
                model_words[model_pos] = model_words[model_pos] ^ (64'(s_tdata) << (8 * model_pos));
                model_pos = model_pos + 3'd1;
            end
            if (s_tuser != OP_ABSORB) finish_digest();
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest word %h", m_tdata[63:0]);
            end else begin
                e = digest_q.pop_front();
                if (e.word !== m_tdata[63:0] || e.index !== m_tdata[66:64] || e.last !== m_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp word %h idx %0d last %0d, got %h idx %0d last %0d",
                                 e.word, e.index, e.last, m_tdata[63:0], m_tdata[66:64], m_tlast);
                end
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 2000;
            end
            if (hold_left > 0) begin
                m_tready <= 0;
                hold_left--;
            end else if (idle_left > 0) begin
                m_tready <= 0;
                idle_left--;
            end else begin
                m_tready <= 1;
                if (!calm && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 19);
            end
        end
    end

    // valid stays up between back-to-back items; it drops when idling or draining
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // wait for every digest word, then for absorbs still in the queue
    task automatic drain();
        s_tvalid <= 0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_rounds(input logic [7:0] v);
        cfg_valid <= 1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model_rounds = v;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // a message of random bytes closed by a finish
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(OP_UNUSED, 8'($urandom));
            send_item(OP_ABSORB, 8'($urandom));
        end
        if ($urandom_range(0, 1)) send_item(OP_ABSORB_FINISH, 8'($urandom));
        else send_item(OP_FINISH, 8'($urandom));
    endtask

    stim_row_t rows [] = '{
        '{OP_ABSORB_FINISH, 8'hff, 1, 64'h0000_0000_0000_00ff},
        '{OP_UNUSED,        8'h5a, 0, 0},
        '{OP_FINISH,        8'hff, 1, 64'h0},
        '{OP_ABSORB,        8'h01, 0, 0},
        '{OP_ABSORB,        8'h02, 0, 0},
        '{OP_ABSORB,        8'h80, 0, 0},
        '{OP_ABSORB,        8'h7f, 0, 0},
        '{OP_ABSORB,        8'h00, 0, 0},
        '{OP_ABSORB,        8'hff, 0, 0},
        '{OP_ABSORB,        8'haa, 0, 0},
        '{OP_ABSORB,        8'h55, 0, 0},
        '{OP_ABSORB,        8'hc3, 0, 0},
        '{OP_ABSORB_FINISH, 8'h3c, 0, 0}
    };

    logic [7:0] phase_rounds [6] = '{8'd1, 8'd2, 8'd5, 8'd3, 8'd40, 8'd7};

    initial begin
        int sent;
        for (int i = 0; i < WORD_COUNT; i++) model_words[i] = 0;
        model_pos = '0;
        model_rounds = ROUND_COUNT_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // reset round count on an empty message
        send_item(OP_FINISH, 8'h00);
        drain();

        // zero rounds: words come out as absorbed
        set_rounds(8'd0);
        foreach (rows[k]) begin
            typed_word0 = rows[k].word0;
            typed_now = rows[k].typed;
            send_item(rows[k].op, rows[k].data);
            typed_now = 0;
        end
        drain();

        // largest round count, once
        set_rounds(8'd255);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_ABSORB_FINISH, 8'h00);
        drain();

        for (int p = 0; p < 6; p++) begin
            set_rounds(phase_rounds[p]);
            if (p == 5) calm = 1;
            if (p == 2) begin
                // receiver holds off while finishes pile up behind it
                hold_req = 1;
                for (int k = 0; k < 6; k++) send_message($urandom_range(0, 3));
            end
            sent = 0;
            while (sent < 40) begin
                int len;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 9);
                send_message(len);
                sent += len + 1;
            end
            drain();
        end

        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
